@@ hdl/rotate_and_isometric_project_macros.svh @@
// Assertion macros for the checker of the rotate/project block.
// Expects clk and rst_n in the scope of each use.
`ifndef ROTATE_AND_ISOMETRIC_PROJECT_MACROS_SVH
`define ROTATE_AND_ISOMETRIC_PROJECT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define RIP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is held.
`define RIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also runs through reset.
`define RIP_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/rip_pkg.sv @@
// Package for the rotate and isometric projection block.
// Fixed-point constants, register codes and the round/saturate helper. No dependencies.
package rip_pkg;

  localparam int unsigned COEF_W         = 16;
  localparam int unsigned COEF_FRAC_BITS = 14;
  localparam int unsigned OUT_W          = 32;
  localparam int unsigned Q_FRAC_BITS    = 8;
  localparam int unsigned ROT_X_SHIFT    = COEF_FRAC_BITS - Q_FRAC_BITS;
  localparam int unsigned PROJ_SHIFT     = 16;
  localparam int unsigned PIPE_STAGES    = 8;

  // cos30 in Q0.16, rounded to nearest; held as a positive signed operand
  localparam logic signed [17:0] COS30_Q16 = 18'sd56756;
  localparam int unsigned        HALF_SHIFT = 15;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_COS_X  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIN_X  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COS_Y  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SIN_Y  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COS_Z  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SIN_Z  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd6;

  localparam logic [COEF_W-1:0] COS_RST    = 16'd16384;
  localparam logic [COEF_W-1:0] SIN_RST    = 16'd0;
  localparam logic [COEF_W-1:0] HEIGHT_RST = 16'd6554;

  typedef logic signed [OUT_W-1:0] q24_8_t;

  // Round half up (add half an LSB, floor shift), then clamp to 32-bit signed.
  function automatic q24_8_t rnd_sat(input logic signed [63:0] v, input int unsigned s);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< (s - 1))) >>> s;
    if (r > 64'sd2147483647) begin
      rnd_sat = 32'sh7fff_ffff;
    end else if (r < -64'sd2147483648) begin
      rnd_sat = 32'sh8000_0000;
    end else begin
      rnd_sat = r[OUT_W-1:0];
    end
  endfunction

endpackage

@@ hdl/rotate_and_isometric_project.sv @@
// Rotate a vertex about X, Y, Z and project it isometrically to Q24.8 screen space.
// Depends on rip_pkg; rip_checker is bound to it from its own file.
//
//  port group | dir | payload
//  -----------+-----+----------------------------------------------
//  in_*       | in  | vert_x, vert_y, vert_z (COORD_BITS each)
//  out_*      | out | screen_x, screen_y, depth_out (32 each)
//  cfg_*      | in  | seven 16-bit registers, APB write/read
//
// Eight register stages, one vertex per cycle sustained while out_tready is high;
// the multiply/round pairs of the three rotations and the projection set the depth.
// rst_n (synchronous) clears the stage valid bits and loads the register defaults.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// close up during a downstream stall and nothing is dropped or duplicated.
module rotate_and_isometric_project
  import rip_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // vert_x, vert_y, vert_z from bit 0 up, zero padded to bytes
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]   in_tdata,
  // screen_x, screen_y, depth_out from bit 0 up
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [3*OUT_W-1:0]                  out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]               cfg_paddr,
  input  logic [CFG_DATA_W-1:0]               cfg_pwdata,
  output logic [CFG_DATA_W-1:0]               cfg_prdata,
  output logic                                cfg_pready
);

  localparam int PX  = COORD_BITS + COEF_W;  // coordinate times coefficient
  localparam int PY  = OUT_W + COEF_W;       // Q24.8 times coefficient
  localparam int SW  = OUT_W + 1;            // sum/difference of two Q24.8
  localparam int PSX = SW + 18;              // difference times cos30
  localparam int PZH = OUT_W + 17;           // depth times height scale

  // ---------------- configuration registers ----------------
  logic [COEF_W-1:0]    cos_x_r, sin_x_r, cos_y_r, sin_y_r, cos_z_r, sin_z_r, height_r;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_x_r  <= COS_RST;
      sin_x_r  <= SIN_RST;
      cos_y_r  <= COS_RST;
      sin_y_r  <= SIN_RST;
      cos_z_r  <= COS_RST;
      sin_z_r  <= SIN_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_COS_X:  cos_x_r  <= cfg_pwdata[COEF_W-1:0];
        REG_SIN_X:  sin_x_r  <= cfg_pwdata[COEF_W-1:0];
        REG_COS_Y:  cos_y_r  <= cfg_pwdata[COEF_W-1:0];
        REG_SIN_Y:  sin_y_r  <= cfg_pwdata[COEF_W-1:0];
        REG_COS_Z:  cos_z_r  <= cfg_pwdata[COEF_W-1:0];
        REG_SIN_Z:  sin_z_r  <= cfg_pwdata[COEF_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_COS_X:  cfg_prdata = {16'd0, cos_x_r};
      REG_SIN_X:  cfg_prdata = {16'd0, sin_x_r};
      REG_COS_Y:  cfg_prdata = {16'd0, cos_y_r};
      REG_SIN_Y:  cfg_prdata = {16'd0, sin_y_r};
      REG_COS_Z:  cfg_prdata = {16'd0, cos_z_r};
      REG_SIN_Z:  cfg_prdata = {16'd0, sin_z_r};
      REG_HEIGHT: cfg_prdata = {16'd0, height_r};
      default:    cfg_prdata = '0;
    endcase
  end

  logic signed [COEF_W-1:0] cx, sx, cy, sy, cz, sz;
  logic signed [COEF_W:0]   hs;

  assign cx = $signed(cos_x_r);
  assign sx = $signed(sin_x_r);
  assign cy = $signed(cos_y_r);
  assign sy = $signed(sin_y_r);
  assign cz = $signed(cos_z_r);
  assign sz = $signed(sin_z_r);
  assign hs = $signed({1'b0, height_r});

  // ---------------- stage control ----------------
  logic [PIPE_STAGES-1:0] vld_r;
  logic [PIPE_STAGES-1:0] stage_en;

  always_comb begin
    stage_en[PIPE_STAGES-1] = !vld_r[PIPE_STAGES-1] || out_tready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
  end

  assign in_tready = stage_en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stage_en[0]) vld_r[0] <= in_tvalid;
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (stage_en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // ---------------- stage 0: X rotation products ----------------
  logic signed [COORD_BITS-1:0] vx, vy, vz;
  logic signed [COORD_BITS-1:0] x0_r;
  logic signed [PX-1:0]         ycx_r, zsx_r, ysx_r, zcx_r;

  assign vx = $signed(in_tdata[COORD_BITS-1:0]);
  assign vy = $signed(in_tdata[2*COORD_BITS-1:COORD_BITS]);
  assign vz = $signed(in_tdata[3*COORD_BITS-1:2*COORD_BITS]);

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      x0_r  <= vx;
      ycx_r <= vy * cx;
      zsx_r <= vz * sx;
      ysx_r <= vy * sx;
      zcx_r <= vz * cx;
    end
  end

  // ---------------- stage 1: X rotation round ----------------
  q24_8_t x1_r, y1_r, z1_r;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      x1_r <= OUT_W'($signed({x0_r, 8'd0}));
      y1_r <= rnd_sat(64'(ycx_r) - 64'(zsx_r), ROT_X_SHIFT);
      z1_r <= rnd_sat(64'(ysx_r) + 64'(zcx_r), ROT_X_SHIFT);
    end
  end

  // ---------------- stage 2: Y rotation products ----------------
  logic signed [PY-1:0] x1cy_r, z1sy_r, z1cy_r, x1sy_r;
  q24_8_t               y1_s2_r;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      x1cy_r  <= x1_r * cy;
      z1sy_r  <= z1_r * sy;
      z1cy_r  <= z1_r * cy;
      x1sy_r  <= x1_r * sy;
      y1_s2_r <= y1_r;
    end
  end

  // ---------------- stage 3: Y rotation round ----------------
  q24_8_t x2_r, z2_r, y1_s3_r;

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      x2_r    <= rnd_sat(64'(x1cy_r) + 64'(z1sy_r), COEF_FRAC_BITS);
      z2_r    <= rnd_sat(64'(z1cy_r) - 64'(x1sy_r), COEF_FRAC_BITS);
      y1_s3_r <= y1_s2_r;
    end
  end

  // ---------------- stage 4: Z rotation products ----------------
  logic signed [PY-1:0] x2cz_r, y1sz_r, x2sz_r, y1cz_r;
  q24_8_t               z2_s4_r;

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      x2cz_r  <= x2_r * cz;
      y1sz_r  <= y1_s3_r * sz;
      x2sz_r  <= x2_r * sz;
      y1cz_r  <= y1_s3_r * cz;
      z2_s4_r <= z2_r;
    end
  end

  // ---------------- stage 5: Z rotation round ----------------
  q24_8_t x3_r, y3_r, z2_s5_r;

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      x3_r    <= rnd_sat(64'(x2cz_r) - 64'(y1sz_r), COEF_FRAC_BITS);
      y3_r    <= rnd_sat(64'(x2sz_r) + 64'(y1cz_r), COEF_FRAC_BITS);
      z2_s5_r <= z2_s4_r;
    end
  end

  // ---------------- stage 6: projection products ----------------
  logic signed [SW-1:0]  xy_dif, xy_sum;
  logic signed [PSX-1:0] sx_prod_r;
  logic signed [SW-1:0]  xy_sum_r;
  logic signed [PZH-1:0] zh_prod_r;
  q24_8_t                z2_s6_r;

  assign xy_dif = SW'(x3_r) - SW'(y3_r);
  assign xy_sum = SW'(x3_r) + SW'(y3_r);

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      sx_prod_r <= xy_dif * COS30_Q16;
      xy_sum_r  <= xy_sum;
      zh_prod_r <= z2_s5_r * hs;
      z2_s6_r   <= z2_s5_r;
    end
  end

  // ---------------- stage 7: output register ----------------
  q24_8_t screen_x_r, screen_y_r, depth_r;

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      screen_x_r <= rnd_sat(64'(sx_prod_r), PROJ_SHIFT);
      // (x+y)/2 in Q0.16 is a shift by 15
      screen_y_r <= rnd_sat((64'(xy_sum_r) <<< HALF_SHIFT) - 64'(zh_prod_r), PROJ_SHIFT);
      depth_r    <= z2_s6_r;
    end
  end

  assign out_tvalid = vld_r[PIPE_STAGES-1];
  assign out_tdata  = {depth_r, screen_y_r, screen_x_r};

endmodule

@@ hdl/rip_checker.sv @@
// Port-level checks for rotate_and_isometric_project, bound to the top level below.
// Depends on rip_pkg and rotate_and_isometric_project_macros.svh.
`include "rotate_and_isometric_project_macros.svh"

module rip_checker
  import rip_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [3*OUT_W-1:0] out_tdata
);

  localparam int CW = $clog2(PIPE_STAGES + 1);

  logic          in_xfer, out_xfer;
  logic [CW-1:0] flight_r, flight_nxt;
  logic [CW-1:0] live_r, live_nxt;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  // vertices inside the block
  always_comb begin
    flight_nxt = flight_r;
    if (in_xfer && !out_xfer) flight_nxt = flight_r + 1'b1;
    if (!in_xfer && out_xfer) flight_nxt = flight_r - 1'b1;
  end

  // reset-free edges seen so far, capped at the pipeline depth
  assign live_nxt = (live_r == CW'(PIPE_STAGES)) ? live_r : live_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flight_r <= '0;
      live_r   <= '0;
    end else begin
      flight_r <= flight_nxt;
      live_r   <= live_nxt;
    end
  end

  `RIP_ASSERT_NEXT_RST(a_reset_empty, !rst_n, !out_tvalid, "out_tvalid set right after reset")
  `RIP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `RIP_ASSERT_IMPLY(a_no_phantom, out_tvalid, flight_r != '0 && flight_r <= CW'(PIPE_STAGES), "result without a vertex in flight")
  `RIP_ASSERT_IMPLY(a_latency, live_r == CW'(PIPE_STAGES) && $past(in_xfer, 8) && $past(out_tready, 1) && $past(out_tready, 2) && $past(out_tready, 3) && $past(out_tready, 4) && $past(out_tready, 5) && $past(out_tready, 6) && $past(out_tready, 7), out_tvalid, "vertex late on a free-running output")

endmodule

bind rotate_and_isometric_project rip_checker u_rip_checker (.*);
